[hw/rtl/upen_pkg.sv]
package upen_pkg;

  // Longest run of result bytes that one input byte can cause.
  localparam int unsigned RUN_MAX = 5;
  localparam int unsigned RUN_W   = $clog2(RUN_MAX + 1);

  typedef logic [7:0] byte_t;

  // One input request.
  typedef struct packed {
    byte_t in_byte;
    logic  in_last;
  } in_req_t;

  // One output request.
  typedef struct packed {
    byte_t out_byte;
    logic  out_run_end;
    logic  out_string_end;
  } out_req_t;

  // A run of result bytes for one input byte, in emission order from index 0.
  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [RUN_W-1:0]        count;
    logic                    last;
  } run_t;

endpackage

[hw/rtl/url_percent_escape_normalizer.sv]
// URL component percent-escape normalizer.
// Input channel: in_valid / in_stall carry one byte of a URL component and a
// flag on its final byte. Output channel: out_valid / out_stall carry the
// normalized bytes, each with a run-end flag (last byte caused by one input
// byte) and a string-end flag (final byte of the normalized string).
// A '%' and the byte after it are held until the second byte after the '%'
// arrives; then the escape is decoded, re-emitted in upper case, or emitted
// as "%25" followed by the held bytes taken again as fresh input.
// A run enters the run queue when its input byte is taken; its first byte
// then reaches the output through the output register. Each input byte causes
// 0 to 5 output bytes; while out_stall is low the back end emits one output
// byte per cycle, so the input takes one byte per cycle while runs are single
// bytes and stalls for longer runs once the QDEPTH-entry run queue fills.
// Reset clears the pending escape, the run queue and the output valid flag.
// When the receiver stalls, the output register holds its byte, the queue
// fills, and in_stall rises when the queue is full.
module url_percent_escape_normalizer #(
  parameter int unsigned QDEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  upen_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output upen_pkg::out_req_t out_req
);
  import upen_pkg::*;

  logic push;
  run_t push_run;
  logic pop;
  run_t head_run;
  logic head_valid;
  logic full;

  assign in_stall = full;

  upen_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .push     (push),
    .push_run (push_run)
  );

  upen_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_run   (push_run),
    .pop        (pop),
    .head_run   (head_run),
    .head_valid (head_valid),
    .full       (full)
  );

  upen_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_run   (head_run),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_req    (out_req)
  );

endmodule

[hw/rtl/upen_front.sv]
module upen_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  upen_pkg::in_req_t in_req,
  output logic              push,
  output upen_pkg::run_t    push_run
);
  import upen_pkg::*;

  localparam byte_t CH_PCT  = 8'h25;
  localparam byte_t CH_TWO  = 8'h32;
  localparam byte_t CH_FIVE = 8'h35;
  localparam byte_t CH_DASH = 8'h2D;
  localparam byte_t CH_DOT  = 8'h2E;
  localparam byte_t CH_UNDS = 8'h5F;
  localparam byte_t CH_TILD = 8'h7E;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PCT,
    PH_DIGIT
  } phase_t;

  phase_t phase_r, phase_nxt;
  byte_t  held_r, held_nxt;
  logic   accept;
  run_t   run;
  byte_t  c;
  byte_t  v;
  logic   last;

  // Only 0-9, A-F and a-f count as hex digits.
  function automatic logic is_hex(input byte_t ch);
    return (ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h41 && ch <= 8'h46) ||
           (ch >= 8'h61 && ch <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input byte_t ch);
    byte_t d;
    if (ch <= 8'h39) begin
      d = ch - 8'h30;
    end else if (ch <= 8'h46) begin
      d = ch - 8'h37;
    end else begin
      d = ch - 8'h57;
    end
    return d[3:0];
  endfunction

  function automatic byte_t upper_hex(input byte_t ch);
    if (ch >= 8'h61 && ch <= 8'h66) begin
      return ch - 8'h20;
    end
    return ch;
  endfunction

  function automatic logic is_unreserved(input byte_t ch);
    return (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A) ||
           (ch >= 8'h30 && ch <= 8'h39) || ch == CH_DASH || ch == CH_DOT ||
           ch == CH_UNDS || ch == CH_TILD;
  endfunction

  assign accept = in_valid && !in_stall;
  assign c      = in_req.in_byte;
  assign last   = in_req.in_last;
  assign v      = {hex_val(held_r), hex_val(c)};

  // Classify the byte against the pending escape and build its run.
  always_comb begin
    run       = '0;
    run.last  = last;
    phase_nxt = phase_r;
    held_nxt  = held_r;
    unique case (phase_r)
      PH_DIGIT: begin
        held_nxt  = '0;
        phase_nxt = PH_IDLE;
        if (is_hex(held_r) && is_hex(c)) begin
          if (is_unreserved(v)) begin
            run.bytes[0] = v;
            run.count    = RUN_W'(1);
          end else begin
            run.bytes[0] = CH_PCT;
            run.bytes[1] = upper_hex(held_r);
            run.bytes[2] = upper_hex(c);
            run.count    = RUN_W'(3);
          end
        end else begin
          // Bad escape: emit "%25", then replay the held byte and this one.
          run.bytes[0] = CH_PCT;
          run.bytes[1] = CH_TWO;
          run.bytes[2] = CH_FIVE;
          if (held_r == CH_PCT) begin
            if (last) begin
              run.bytes[3] = CH_PCT;
              run.bytes[4] = c;
              run.count    = RUN_W'(5);
            end else begin
              held_nxt  = c;
              phase_nxt = PH_DIGIT;
              run.count = RUN_W'(3);
            end
          end else begin
            run.bytes[3] = held_r;
            if (c == CH_PCT && !last) begin
              phase_nxt = PH_PCT;
              run.count = RUN_W'(4);
            end else begin
              run.bytes[4] = c;
              run.count    = RUN_W'(5);
            end
          end
        end
      end
      PH_PCT: begin
        if (last) begin
          // Escape cut short by the end of the string.
          run.bytes[0] = CH_PCT;
          run.bytes[1] = c;
          run.count    = RUN_W'(2);
          phase_nxt    = PH_IDLE;
        end else begin
          held_nxt  = c;
          phase_nxt = PH_DIGIT;
        end
      end
      default: begin
        if (c == CH_PCT && !last) begin
          phase_nxt = PH_PCT;
        end else begin
          run.bytes[0] = c;
          run.count    = RUN_W'(1);
          phase_nxt    = PH_IDLE;
        end
      end
    endcase
  end

  // Bytes that open or continue an escape push nothing.
  assign push     = accept && (run.count != '0);
  assign push_run = run;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

`ifndef SYNTHESIS
  // The end of a string always leaves no escape pending.
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && last |=> phase_r == PH_IDLE)
    else $error("escape still pending after last byte");
`endif

endmodule

[hw/rtl/upen_queue.sv]
module upen_queue #(
  parameter int unsigned QDEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  upen_pkg::run_t push_run,
  input  logic           pop,
  output upen_pkg::run_t head_run,
  output logic           head_valid,
  output logic           full
);
  import upen_pkg::*;

  localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  run_t             mem_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QDEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign head_valid = (count_r != '0);
  assign full       = (count_r == CNT_W'(QDEPTH));
  assign head_run   = mem_r[rd_ptr_r];

  // Run storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_run;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wrap_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= wrap_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QDEPTH))
    else $error("run queue overflow");
`endif

endmodule

[hw/rtl/upen_back.sv]
module upen_back (
  input  logic               clk,
  input  logic               rst_n,
  input  upen_pkg::run_t     head_run,
  input  logic               head_valid,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output upen_pkg::out_req_t out_req
);
  import upen_pkg::*;

  logic [RUN_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r;
  out_req_t         out_req_r, out_req_nxt;
  logic             load;
  logic             final_byte;

  // The output register takes a new byte when empty or being drained.
  assign load       = head_valid && (!out_valid_r || !out_stall);
  assign final_byte = (RUN_W'(idx_r + RUN_W'(1)) == head_run.count);
  assign pop        = load && final_byte;
  assign idx_nxt    = final_byte ? '0 : idx_r + RUN_W'(1);

  always_comb begin
    out_req_nxt.out_byte       = head_run.bytes[idx_r];
    out_req_nxt.out_run_end    = final_byte;
    out_req_nxt.out_string_end = final_byte && head_run.last;
  end

  // Byte index within the head run and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (load) begin
      idx_r       <= idx_nxt;
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (load) begin
      out_req_r <= out_req_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

`ifndef SYNTHESIS
  a_string_end_on_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_req_r.out_string_end |-> out_req_r.out_run_end)
    else $error("string end without run end");

  a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> idx_r < head_run.count)
    else $error("byte index past end of run");
`endif

endmodule

[verif/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import upen_pkg::*;

  // Escape state of the local copy of the normalizer.
  typedef enum logic [1:0] {
    ESC_NONE,
    ESC_PERCENT,
    ESC_DIGIT
  } esc_phase_t;

  localparam byte_t CH_PERCENT = 8'h25;
  localparam byte_t CH_TWO     = 8'h32;
  localparam byte_t CH_FIVE    = 8'h35;

  localparam int N_DIRECTED   = 25;
  localparam int RANDOM_ITEMS = 250;
  localparam int QUIET_ITEMS  = 50;
  localparam int PAUSE_AT     = 100;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 400000;

  // One row of the directed stimulus. When typed is set, exp holds the
  // bytes the row must produce; otherwise the predictor supplies them.
  typedef struct {
    byte_t b;
    bit    last;
    bit    typed;
    int    n;
    byte_t exp [5];
  } dir_row_t;

  dir_row_t dir_table [N_DIRECTED] = '{
    '{8'h00, 1'b0, 1'b1, 1, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
    '{8'hFF, 1'b1, 1'b1, 1, '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h00}},
    '{8'h25, 1'b0, 1'b1, 0, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
    '{8'h34, 1'b0, 1'b1, 0, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
    '{8'h31, 1'b0, 1'b1, 1, '{8'h41, 8'h00, 8'h00, 8'h00, 8'h00}},
    '{8'h25, 1'b0, 1'b1, 0, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
    '{8'h32, 1'b0, 1'b1, 0, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
    '{8'h66, 1'b0, 1'b1, 3, '{8'h25, 8'h32, 8'h46, 8'h00, 8'h00}},
    '{8'h25, 1'b0, 1'b0, 0, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
    '{8'h37, 1'b0, 1'b0, 0, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
    '{8'h65, 1'b1, 1'b1, 1, '{8'h7E, 8'h00, 8'h00, 8'h00, 8'h00}},
    '{8'h25, 1'b0, 1'b1, 0, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
    '{8'h47, 1'b0, 1'b1, 0, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
    '{8'h25, 1'b0, 1'b1, 4, '{8'h25, 8'h32, 8'h35, 8'h47, 8'h00}},
    '{8'h2D, 1'b0, 1'b1, 0, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
    '{8'h20, 1'b0, 1'b1, 5, '{8'h25, 8'h32, 8'h35, 8'h2D, 8'h20}},
    '{8'h25, 1'b1, 1'b1, 1, '{8'h25, 8'h00, 8'h00, 8'h00, 8'h00}},
    '{8'h25, 1'b0, 1'b1, 0, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
    '{8'h61, 1'b1, 1'b1, 2, '{8'h25, 8'h61, 8'h00, 8'h00, 8'h00}},
    '{8'h25, 1'b0, 1'b0, 0, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
    '{8'h25, 1'b0, 1'b0, 0, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
    '{8'h25, 1'b1, 1'b1, 5, '{8'h25, 8'h32, 8'h35, 8'h25, 8'h25}},
    '{8'h25, 1'b0, 1'b0, 0, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
    '{8'h2B, 1'b0, 1'b0, 0, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
    '{8'h35, 1'b1, 1'b1, 5, '{8'h25, 8'h32, 8'h35, 8'h2B, 8'h35}}
  };

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  in_req_t  in_req    = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_req_t out_req;

  // Predictor state and the store of bytes still owed by the block.
  esc_phase_t esc_phase = ESC_NONE;
  byte_t      held_byte = '0;
  byte_t      run_bytes[$];
  out_req_t   expected_bytes[$];
  byte_t      text[$];

  bit idle_on        = 1'b1;
  int stall_left     = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;

  url_percent_escape_normalizer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit is_hex_digit(byte_t c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_value(byte_t c);
    if (c <= 8'h39) return 4'(c - 8'h30);
    if (c <= 8'h46) return 4'(c - 8'h41 + 8'd10);
    return 4'(c - 8'h61 + 8'd10);
  endfunction

  function automatic byte_t hex_upper(byte_t c);
    return (c >= 8'h61 && c <= 8'h66) ? c - 8'h20 : c;
  endfunction

  function automatic bit is_unreserved(byte_t v);
    return (v >= 8'h41 && v <= 8'h5A) || (v >= 8'h61 && v <= 8'h7A) ||
           (v >= 8'h30 && v <= 8'h39) || v == 8'h2D || v == 8'h2E ||
           v == 8'h5F || v == 8'h7E;
  endfunction

  // Hex digit for a nibble, in either case.
  function automatic byte_t hex_char(logic [3:0] n, bit lower);
    if (n < 4'd10) return 8'h30 + n;
    return (lower ? 8'h61 : 8'h41) + n - 8'd10;
  endfunction

  // Takes one byte while no escape is held or only the percent sign is held.
  function automatic void take_plain(byte_t c, bit last);
    if (esc_phase == ESC_PERCENT) begin
      if (last) begin
        run_bytes.push_back(CH_PERCENT);
        run_bytes.push_back(c);
        esc_phase = ESC_NONE;
      end else begin
        held_byte = c;
        esc_phase = ESC_DIGIT;
      end
    end else if (c == CH_PERCENT && !last) begin
      esc_phase = ESC_PERCENT;
    end else begin
      esc_phase = ESC_NONE;
      run_bytes.push_back(c);
    end
  endfunction

  // Works out the bytes one input request causes and advances the state.
  function automatic void normalize_byte(in_req_t r);
    byte_t h;
    byte_t v;
    run_bytes.delete();
    if (esc_phase == ESC_DIGIT) begin
      h = held_byte;
      held_byte = '0;
      esc_phase = ESC_NONE;
      if (is_hex_digit(h) && is_hex_digit(r.in_byte)) begin
        v = {hex_value(h), hex_value(r.in_byte)};
        if (is_unreserved(v)) begin
          run_bytes.push_back(v);
        end else begin
          run_bytes.push_back(CH_PERCENT);
          run_bytes.push_back(hex_upper(h));
          run_bytes.push_back(hex_upper(r.in_byte));
        end
      end else begin
        // A broken escape becomes "%25" and both held bytes start over.
        run_bytes.push_back(CH_PERCENT);
        run_bytes.push_back(CH_TWO);
        run_bytes.push_back(CH_FIVE);
        take_plain(h, 1'b0);
        take_plain(r.in_byte, r.in_last);
      end
    end else begin
      take_plain(r.in_byte, r.in_last);
    end
  endfunction

  // Moves the current run into the store, flagging its final byte.
  function automatic void queue_run(bit last);
    out_req_t o;
    foreach (run_bytes[i]) begin
      o.out_byte       = run_bytes[i];
      o.out_run_end    = (i == run_bytes.size() - 1);
      o.out_string_end = o.out_run_end && last;
      expected_bytes.push_back(o);
    end
  endfunction

  // Builds one component string from plain bytes and escapes of every kind.
  function automatic void build_text();
    int    sel;
    byte_t v;
    text.delete();
    repeat ($urandom_range(1, 6)) begin
      sel = $urandom_range(0, 7);
      v = 8'($urandom);
      unique case (sel)
        0, 1: begin
          text.push_back(v);
        end
        2, 3, 4: begin
          while (sel == 4 && !is_unreserved(v)) v = 8'($urandom);
          text.push_back(CH_PERCENT);
          text.push_back(hex_char(v[7:4], 1'($urandom_range(0, 1))));
          text.push_back(hex_char(v[3:0], 1'($urandom_range(0, 1))));
        end
        5: begin
          text.push_back(CH_PERCENT);
          text.push_back(v);
          text.push_back(8'($urandom));
        end
        6: begin
          text.push_back(CH_PERCENT);
        end
        default: begin
          text.push_back(CH_PERCENT);
          text.push_back(hex_char(v[3:0], v[4]));
        end
      endcase
    end
  endfunction

  // Offers one request, with an occasional gap first, and predicts its run.
  task automatic send_byte(in_req_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (in_stall);
    normalize_byte(r);
  endtask

  task automatic note_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // Stimulus: reset, the directed table, then random strings.
  initial begin
    in_req_t r;
    int      k;
    int      j;
    int      sent;
    bit      noise;
    bit      paused;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < N_DIRECTED; k++) begin
      r.in_byte = dir_table[k].b;
      r.in_last = dir_table[k].last;
      send_byte(r);
      if (dir_table[k].typed) begin
        run_bytes.delete();
        for (j = 0; j < dir_table[k].n; j++) run_bytes.push_back(dir_table[k].exp[j]);
      end
      queue_run(r.in_last);
    end

    sent = 0;
    paused = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      idle_on = (sent < RANDOM_ITEMS - QUIET_ITEMS) && ((sent / 40) % 3 != 2);
      // Let the block drain completely once in the middle of the run.
      if (!paused && sent >= PAUSE_AT) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_bytes.size() != 0) @(posedge clk);
      end
      // Most strings are well formed; some carry random end flags.
      noise = ($urandom_range(0, 5) == 0);
      build_text();
      foreach (text[i]) begin
        r.in_byte = text[i];
        r.in_last = noise ? ($urandom_range(0, 7) == 0) : (i == text.size() - 1);
        send_byte(r);
        queue_run(r.in_last);
        sent++;
      end
    end

    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Receiver stalls in random bursts while idle_on is set.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_on && rst_n && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 10);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Each accepted request is checked against the oldest expectation.
  always @(posedge clk) begin
    out_req_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        note_mismatch($sformatf("unexpected byte %02h run_end %b string_end %b",
                                out_req.out_byte, out_req.out_run_end,
                                out_req.out_string_end));
      end else begin
        want = expected_bytes.pop_front();
        if (out_req.out_byte !== want.out_byte ||
            out_req.out_run_end !== want.out_run_end ||
            out_req.out_string_end !== want.out_string_end) begin
          note_mismatch($sformatf(
            "expected byte %02h run_end %b string_end %b, got %02h %b %b",
            want.out_byte, want.out_run_end, want.out_string_end,
            out_req.out_byte, out_req.out_run_end, out_req.out_string_end));
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule

[sim.f]
hw/rtl/upen_pkg.sv
hw/rtl/upen_front.sv
hw/rtl/upen_queue.sv
hw/rtl/upen_back.sv
hw/rtl/url_percent_escape_normalizer.sv
verif/tb_top.sv
